FILE: hw/rtl/double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define DQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/dq_pkg.sv
// Shared constants, codes, types and helpers of the double-ended queue.
package dq_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_LIST       = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_POP_BACK   = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic    wr_front;
        logic    wr_back;
        logic    pop_front;
        logic    pop_back;
        logic    rd_first;
        logic    rd_next;
        logic    out_load;
        logic    out_from_ram;
        status_t out_status;
        logic    out_last;
    } dq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
    } dq_stat_t;

    // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/dq_datapath.sv
// Datapath: ring storage, head and count registers, list offset, result payload.
`include "double_ended_queue_defines.svh"

module dq_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dq_pkg::dq_cmd_t                   cmd,
    output dq_pkg::dq_stat_t                  stat,
    input  logic signed [dq_pkg::DATA_W-1:0]  s_value,
    output logic signed [dq_pkg::DATA_W-1:0]  m_value_res,
    output logic [dq_pkg::STAT_W-1:0]         m_status,
    output logic                              m_last
);
    import dq_pkg::*;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  ofs_reg, ofs_next;
    logic [IDX_W-1:0]  head_dec, head_inc;
    logic [CNT_W-1:0]  ofs_inc;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] value_res_reg;
    logic [STAT_W-1:0] status_reg;
    logic              last_reg;

    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign ofs_inc  = CNT_W'(ofs_reg) + CNT_W'(1);

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg >= CNT_W'(DEPTH));
    assign stat.list_last = (ofs_inc == count_reg);

    assign wr_en   = cmd.wr_front | cmd.wr_back;
    assign wr_addr = cmd.wr_front ? head_dec : wrap_add(head_reg, count_reg);
    assign rd_en   = cmd.rd_first | cmd.rd_next;
    assign rd_addr = cmd.rd_first ? head_reg : wrap_add(head_reg, ofs_inc);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        ofs_next   = ofs_reg;
        if (cmd.wr_front) begin
            head_next  = head_dec;
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.wr_back) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop_front) begin
            head_next  = head_inc;
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.pop_back) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.rd_first) begin
            ofs_next = '0;
        end else if (cmd.rd_next) begin
            ofs_next = ofs_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            ofs_reg   <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            ofs_reg   <= ofs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            value_res_reg <= cmd.out_from_ram ? $signed(rd_data) : '0;
            status_reg    <= cmd.out_status;
            last_reg      <= cmd.out_last;
        end
    end

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_value_res = value_res_reg;
    assign m_status    = status_reg;
    assign m_last      = last_reg;

    `DQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "count above depth")
    `DQ_ASSERT(a_cmd_excl, aclk, aresetn, $onehot0({cmd.wr_front, cmd.wr_back, cmd.pop_front, cmd.pop_back, cmd.rd_first, cmd.rd_next}), "conflicting commands")
    `DQ_ASSERT(a_push_count, aclk, aresetn, (aresetn && wr_en) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "push did not grow count")

endmodule

FILE: hw/rtl/dq_ctrl.sv
// Controller: operation decode, list sequencing and result valid.
`include "double_ended_queue_defines.svh"

module dq_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [dq_pkg::FUNC_W-1:0]  s_func,
    output logic                       m_valid,
    input  logic                       m_ready,
    output dq_pkg::dq_cmd_t            cmd,
    input  dq_pkg::dq_stat_t           stat
);
    import dq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        cmd          = '0;
        cmd.out_status = ST_OK;
        state_next   = state_reg;
        if (state_reg == S_IDLE) begin
            if (accept) begin
                cmd.out_last = 1'b1;
                case (func_t'(s_func))
                    FN_PUSH_FRONT: begin
                        cmd.out_load   = 1'b1;
                        cmd.wr_front   = !stat.full;
                        cmd.out_status = stat.full ? ST_OVERFLOW : ST_OK;
                    end
                    FN_PUSH_BACK: begin
                        cmd.out_load   = 1'b1;
                        cmd.wr_back    = !stat.full;
                        cmd.out_status = stat.full ? ST_OVERFLOW : ST_OK;
                    end
                    FN_POP_FRONT: begin
                        cmd.out_load   = 1'b1;
                        cmd.pop_front  = !stat.empty;
                        cmd.out_status = stat.empty ? ST_UNDERFLOW : ST_OK;
                    end
                    FN_POP_BACK: begin
                        cmd.out_load   = 1'b1;
                        cmd.pop_back   = !stat.empty;
                        cmd.out_status = stat.empty ? ST_UNDERFLOW : ST_OK;
                    end
                    FN_LIST: begin
                        if (stat.empty) begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_EMPTY;
                        end else begin
                            cmd.rd_first = 1'b1;
                            state_next   = S_LIST;
                        end
                    end
                    default: begin
                        cmd.out_last = 1'b0;
                    end
                endcase
            end
        end else begin
            // RAM output holds entry at current offset; prefetch the next one
            if (out_free) begin
                cmd.out_load     = 1'b1;
                cmd.out_from_ram = 1'b1;
                cmd.out_last     = stat.list_last;
                cmd.rd_next      = !stat.list_last;
                if (stat.list_last) begin
                    state_next = S_IDLE;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `DQ_ASSERT(a_load_valid, aclk, aresetn, (aresetn && cmd.out_load) |=> m_valid_reg, "loaded item not presented")
    `DQ_ASSERT(a_list_end, aclk, aresetn, (aresetn && state_reg == S_LIST && out_free && stat.list_last) |=> (state_reg == S_IDLE), "list did not finish")
    `DQ_ASSERT(a_list_nowr, aclk, aresetn, (state_reg == S_LIST) |-> !(cmd.wr_front || cmd.wr_back || cmd.pop_front || cmd.pop_back || s_ready), "update during list")

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
// Usage:
//   Input channel s_valid/s_ready carries one item: s_func selects push front (0),
//   push back (1), list (2), pop front (3) or pop back (4); s_value is the value
//   pushed. Codes 5 to 7 are taken and dropped with no result.
//   Result channel m_valid/m_ready carries m_value_res, m_status and m_last.
//   Push and pop give one status item in the cycle after acceptance, and a new
//   item is taken every cycle as long as results drain.
//   A list gives one item per stored entry, front to back, with m_last on the
//   final one, at one entry per cycle from the single RAM read port while the
//   receiver keeps up; a new item is taken once the list ends and the output is free.
//   A list of an empty queue gives one item with status "list empty".
//   Reset clears head and count; the storage itself is not cleared and needs
//   no clearing pass, so an item is accepted the first cycle after reset.
//   When the receiver stalls, the result waits in the output register and
//   the block holds s_ready low until that slot is free again.
module double_ended_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dq_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [dq_pkg::DATA_W-1:0]  s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [dq_pkg::DATA_W-1:0]  m_value_res,
    output logic [dq_pkg::STAT_W-1:0]         m_status,
    output logic                              m_last
);
    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    dq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_value     (s_value),
        .m_value_res (m_value_res),
        .m_status    (m_status),
        .m_last      (m_last)
    );

endmodule
